### rtl/decimal_text_to_signed_int_unit_defines.svh
// Assertion macros for the decimal text to signed integer unit.
`ifndef DECIMAL_TEXT_TO_SIGNED_INT_UNIT_DEFINES_SVH
`define DECIMAL_TEXT_TO_SIGNED_INT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define DTSI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtsi: implication check failed");
// Next-cycle implication, checked out of reset.
`define DTSI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtsi: next-cycle check failed");
`else
`define DTSI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DTSI_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/dtsi_pkg.sv
// Shared constants and types of the decimal text to signed integer unit.
`default_nettype none

package dtsi_pkg;

   localparam int VALUE_BITS = 64;            // accumulator width, 16..64
   localparam int VALUE_W    = 64;            // result value field width
   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 16;
   localparam int PROD_W     = VALUE_BITS + 4; // room for magnitude * 10 + digit

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Parser state captured when a number ends.
   typedef struct packed {
      logic [VALUE_BITS-1:0] magnitude;
      logic                  negative;
      logic                  wrapped;
      logic                  digit_seen;
      logic [COUNT_W-1:0]    count;
      logic                  delim;
   } snap_type;

endpackage

`default_nettype wire

### rtl/dtsi_if.sv
// Channel interfaces: character requests and parse results.
`default_nettype none

interface dtsi_req_if import dtsi_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dtsi_rsp_if import dtsi_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      invalid;
   logic                      overflow;
   logic                      underflow;
   logic [COUNT_W-1:0]        consumed;
   logic                      ended_by_delimiter;

   modport source (output valid, output value, output invalid, output overflow,
                   output underflow, output consumed, output ended_by_delimiter,
                   input ready);
   modport sink   (input valid, input value, input invalid, input overflow,
                   input underflow, input consumed, input ended_by_delimiter,
                   output ready);
endinterface

`default_nettype wire

### rtl/decimal_text_to_signed_int_unit.sv
// Top level: streaming ASCII decimal to signed 64-bit integer parser.
//
//  channel  | dir | payload                                        | handshake
//  req_ch   | in  | char_code[7:0], last_char                       | valid/ready
//  rsp_ch   | out | value[63:0] signed, invalid, overflow,          | valid/ready
//           |     | underflow, consumed[15:0], ended_by_delimiter   |
//
// One character per cycle while no result stall holds the input; the next
// character's state depends on the previous one through the parse state,
// the 64-bit shift-add magnitude among it. A result is offered once its
// number's ending character passes the input, snapshot and result registers.
// Synchronous reset clears all parse state and valid flags.
// A stalled result only holds up characters that end a number while both
// the snapshot and result registers are full.
`default_nettype none
`include "decimal_text_to_signed_int_unit_defines.svh"

module decimal_text_to_signed_int_unit import dtsi_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dtsi_req_if.sink  req_ch,
   dtsi_rsp_if.source rsp_ch
);

   snap_type snap;
   logic     snap_valid;
   logic     snap_ready;

   dtsi_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .snap       (snap),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready)
   );

   dtsi_result u_result (
      .clock      (clock),
      .reset      (reset),
      .snap       (snap),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .rsp_ch     (rsp_ch)
   );

   // any error flag forces a zero value
   `DTSI_ASSERT_IMP(a_err_zero, clock, reset,
      rsp_ch.valid && (rsp_ch.invalid || rsp_ch.overflow || rsp_ch.underflow),
      rsp_ch.value == '0)
   // no digits means nothing accumulated, so no range error
   `DTSI_ASSERT_IMP(a_inv_clean, clock, reset,
      rsp_ch.valid && rsp_ch.invalid,
      !rsp_ch.overflow && !rsp_ch.underflow)
   // nothing consumed: the number was ended by a delimiter with no digits
   `DTSI_ASSERT_IMP(a_empty_delim, clock, reset,
      rsp_ch.valid && (rsp_ch.consumed == '0),
      rsp_ch.invalid && rsp_ch.ended_by_delimiter)
   // a snapshot waiting on a stalled result register stays pending
   `DTSI_ASSERT_NXT(a_snap_hold, clock, reset, snap_valid && !snap_ready, snap_valid)

endmodule

`default_nettype wire

### rtl/dtsi_parse.sv
// Input register, per-character parse state and end-of-number snapshot register.
`default_nettype none

module dtsi_parse import dtsi_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dtsi_req_if.sink  req_ch,
   output snap_type  snap,
   output logic      snap_valid,
   input  wire logic snap_ready
);

   typedef enum logic {PH_LEAD, PH_BODY} phase_type;

   phase_type             phase_ff, phase_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0]     s1_char_ff;
   logic                  s1_last_ff;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  wrap_ff, wrap_in;
   logic                  dseen_ff, dseen_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  snap_valid_ff, snap_valid_in;
   snap_type              snap_ff, snap_in;

   logic              req_fire, s1_adv, emit;
   logic              is_digit, take_ws, take_minus, consume;
   logic [PROD_W-1:0] prod;

   assign is_digit   = (s1_char_ff >= CH_ZERO) && (s1_char_ff <= CH_NINE);
   assign take_ws    = (phase_ff == PH_LEAD) &&
                       ((s1_char_ff == CH_SPACE) || (s1_char_ff == CH_TAB));
   assign take_minus = (phase_ff == PH_LEAD) && (s1_char_ff == CH_MINUS);
   assign consume    = take_ws || take_minus || is_digit;
   assign emit       = !consume || s1_last_ff;

   // magnitude * 10 + digit as shift-add; bits above VALUE_BITS flag a wrap
   assign prod = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) +
                 PROD_W'(s1_char_ff[3:0]);

   assign s1_adv   = s1_valid_ff && (!emit || !snap_valid_ff || snap_ready);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_adv;

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      wrap_in  = wrap_ff;
      dseen_in = dseen_ff;
      count_in = count_ff;
      if (take_minus) begin
         neg_in   = 1'b1;
         phase_in = PH_BODY;
      end
      if (is_digit) begin
         mag_in   = prod[VALUE_BITS-1:0];
         wrap_in  = wrap_ff || (|prod[PROD_W-1:VALUE_BITS]);
         dseen_in = 1'b1;
         phase_in = PH_BODY;
      end
      if (consume && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end

      snap_in.magnitude  = mag_in;
      snap_in.negative   = neg_in;
      snap_in.wrapped    = wrap_in;
      snap_in.digit_seen = dseen_in;
      snap_in.count      = count_in;
      snap_in.delim      = !consume;

      s1_valid_in   = (s1_valid_ff && !s1_adv) || req_fire;
      snap_valid_in = (snap_valid_ff && !snap_ready) || (s1_adv && emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         phase_ff      <= PH_LEAD;
         neg_ff        <= 1'b0;
         mag_ff        <= '0;
         wrap_ff       <= 1'b0;
         dseen_ff      <= 1'b0;
         count_ff      <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         snap_valid_ff <= snap_valid_in;
         if (req_fire) begin
            s1_char_ff <= req_ch.char_code;
            s1_last_ff <= req_ch.last_char;
         end
         if (s1_adv && emit) begin
            snap_ff  <= snap_in;
            phase_ff <= PH_LEAD;
            neg_ff   <= 1'b0;
            mag_ff   <= '0;
            wrap_ff  <= 1'b0;
            dseen_ff <= 1'b0;
            count_ff <= '0;
         end else if (s1_adv) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            mag_ff   <= mag_in;
            wrap_ff  <= wrap_in;
            dseen_ff <= dseen_in;
            count_ff <= count_in;
         end
      end
   end

   assign snap       = snap_ff;
   assign snap_valid = snap_valid_ff;

endmodule

`default_nettype wire

### rtl/dtsi_result.sv
// Range checks, sign application and the result register.
`default_nettype none

module dtsi_result import dtsi_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire snap_type  snap,
   input  wire logic      snap_valid,
   output logic           snap_ready,
   dtsi_rsp_if.source     rsp_ch
);

   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      inv_ff, ovf_ff, unf_ff, delim_ff;
   logic                      inv_in, ovf_in, unf_in;
   logic [COUNT_W-1:0]        count_ff;
   logic                      msb, low_zero;
   logic signed [VALUE_BITS-1:0] signed_mag;

   assign msb      = snap.magnitude[VALUE_BITS-1];
   assign low_zero = ~|snap.magnitude[VALUE_BITS-2:0];

   always_comb begin
      inv_in = !snap.digit_seen;
      // above the signed max: overflow when positive or when the magnitude wrapped, underflow past -2^(N-1)
      ovf_in = snap.wrapped || (msb && !snap.negative);
      unf_in = msb && snap.negative && !low_zero;
      signed_mag = snap.negative ? -$signed(snap.magnitude) : $signed(snap.magnitude);
      value_in = (inv_in || ovf_in || unf_in) ? '0 : VALUE_W'(signed_mag);
      valid_in = (valid_ff && !rsp_ch.ready) || snap_valid;
   end

   assign snap_ready = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (snap_valid && snap_ready) begin
            value_ff <= value_in;
            inv_ff   <= inv_in;
            ovf_ff   <= ovf_in;
            unf_ff   <= unf_in;
            count_ff <= snap.count;
            delim_ff <= snap.delim;
         end
      end
   end

   assign rsp_ch.valid              = valid_ff;
   assign rsp_ch.value              = value_ff;
   assign rsp_ch.invalid            = inv_ff;
   assign rsp_ch.overflow           = ovf_ff;
   assign rsp_ch.underflow          = unf_ff;
   assign rsp_ch.consumed           = count_ff;
   assign rsp_ch.ended_by_delimiter = delim_ff;

endmodule

`default_nettype wire
